### sv/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Types and constants shared by the UTF-8 to UCS-2 decoder and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package u2u_pkg;

  // Default width of the per-string unit counter.
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Width of one decoded code unit and of the shown unit count.
  localparam int unsigned UNIT_W = 16;

  // Unit that replaces a value that does not fit in 16 bits.
  localparam logic [UNIT_W-1:0] UNIT_REPLACE = 16'h003F;

  // Reason a string finished.
  typedef enum logic [1:0] {
    CAUSE_RUN  = 2'd0,
    CAUSE_NULL = 2'd1,
    CAUSE_END  = 2'd2,
    CAUSE_BAD  = 2'd3
  } cause_t;

  // One input byte with its string marks.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              unit_valid;
    logic              finished;
    cause_t            end_cause;
    logic [UNIT_W-1:0] units_done;
  } out_item_t;

endpackage

`default_nettype wire

### sv/utf8_to_ucs2_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_unit
// Decodes a UTF-8 byte stream into 16-bit code units, one byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while in_stall is low: the byte
// is decoded against the sequence state in the same cycle as its transfer.
// Results sit in an output register backed by one skid register, which fills
// only while the output holds a stalled result, so in_stall rises only when
// both hold a result that has not been taken; it is a registered signal with
// no combinational path from out_stall. Bytes that only extend a pending
// sequence and skipped bytes produce a result only when marked last; bytes
// after the end of a string produce none. Lead bytes of up to six bytes
// are accepted, overlong forms included; values above 16 bits give '?'.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_decoder_unit #(
  parameter int unsigned COUNT_BITS = u2u_pkg::COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire u2u_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output u2u_pkg::out_item_t      out_data
);

  import u2u_pkg::*;

  // Decoder state.
  logic [2:0]            pend_r,  pend_nxt;
  logic [31:0]           acc_r,   acc_nxt;
  logic [COUNT_BITS-1:0] cnt_r,   cnt_nxt;
  logic                  halt_r,  halt_nxt;

  // Output register and skid register.
  logic      out_valid_r,  out_valid_nxt;
  out_item_t out_data_r,   out_data_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t skid_data_r,  skid_data_nxt;

  // Per-byte decode signals.
  logic                  in_xfer;
  logic [2:0]            pend_b;
  logic [31:0]           acc_b;
  logic [COUNT_BITS-1:0] cnt_b;
  logic                  halt_b;
  logic [2:0]            ones;
  logic [31:0]           lead_acc;
  logic [31:0]           cont_bits;
  logic [7:0]            byte_in;
  logic                  last_in;
  logic                  do_unit;
  logic                  res_valid;
  logic [UNIT_W-1:0]     res_unit;
  logic                  res_unit_valid;
  cause_t                res_cause;
  logic [UNIT_W-1:0]     shown_cnt;
  out_item_t             res_item;

  assign in_xfer = in_valid && !in_stall;
  assign byte_in = in_data.byte_value;
  assign last_in = in_data.last_byte;

  // Leading-ones count of the byte and the payload bits of a lead byte.
  always_comb begin
    case (byte_in) inside
      8'b0???????: begin
        ones     = 3'd0;
        lead_acc = {24'd0, byte_in};
      end
      8'b10??????: begin
        ones     = 3'd1;
        lead_acc = '0;
      end
      8'b110?????: begin
        ones     = 3'd2;
        lead_acc = {21'd0, byte_in[4:0], 6'd0};
      end
      8'b1110????: begin
        ones     = 3'd3;
        lead_acc = {16'd0, byte_in[3:0], 12'd0};
      end
      8'b11110???: begin
        ones     = 3'd4;
        lead_acc = {11'd0, byte_in[2:0], 18'd0};
      end
      8'b111110??: begin
        ones     = 3'd5;
        lead_acc = {6'd0, byte_in[1:0], 24'd0};
      end
      8'b1111110?: begin
        ones     = 3'd6;
        lead_acc = {1'b0, byte_in[0], 30'd0};
      end
      default: begin
        ones     = 3'd7;
        lead_acc = '0;
      end
    endcase
  end

  // State as seen by this byte: a first mark starts from a clean slate.
  always_comb begin
    if (in_data.first_byte) begin
      pend_b = '0;
      acc_b  = '0;
      cnt_b  = '0;
      halt_b = 1'b0;
    end else begin
      pend_b = pend_r;
      acc_b  = acc_r;
      cnt_b  = cnt_r;
      halt_b = halt_r;
    end
  end

  // Continuation payload placed by the number of bytes still expected.
  always_comb begin
    case (pend_b)
      3'd1:    cont_bits = {26'd0, byte_in[5:0]};
      3'd2:    cont_bits = {20'd0, byte_in[5:0], 6'd0};
      3'd3:    cont_bits = {14'd0, byte_in[5:0], 12'd0};
      3'd4:    cont_bits = {8'd0, byte_in[5:0], 18'd0};
      3'd5:    cont_bits = {2'd0, byte_in[5:0], 24'd0};
      default: cont_bits = '0;
    endcase
  end

  // Main decode of one transferred byte.
  always_comb begin
    pend_nxt       = pend_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    halt_nxt       = halt_r;
    do_unit        = 1'b0;
    res_valid      = 1'b0;
    res_unit       = '0;
    res_unit_valid = 1'b0;
    res_cause      = CAUSE_RUN;

    if (in_xfer) begin
      pend_nxt = pend_b;
      acc_nxt  = acc_b;
      cnt_nxt  = cnt_b;
      halt_nxt = halt_b;

      if (!halt_b) begin
        if (pend_b == 3'd0) begin
          if (ones == 3'd1 || ones == 3'd7) begin
            // Lone continuation or invalid lead: skip the byte.
            if (last_in) begin
              res_valid = 1'b1;
              res_cause = CAUSE_END;
            end
          end else if (ones == 3'd0) begin
            acc_nxt = lead_acc;
            do_unit = 1'b1;
          end else begin
            acc_nxt  = lead_acc;
            pend_nxt = ones - 3'd1;
            if (last_in) begin
              res_valid = 1'b1;
              res_cause = CAUSE_BAD;
            end
          end
        end else if (byte_in[7:6] != 2'b10) begin
          // Broken sequence: the byte is consumed and the string ends.
          res_valid = 1'b1;
          res_cause = CAUSE_BAD;
        end else begin
          acc_nxt  = acc_b | cont_bits;
          pend_nxt = pend_b - 3'd1;
          if (pend_b == 3'd1) begin
            do_unit = 1'b1;
          end else if (last_in) begin
            res_valid = 1'b1;
            res_cause = CAUSE_BAD;
          end
        end
      end

      // Completed sequence: emit one unit and count it.
      if (do_unit) begin
        res_valid      = 1'b1;
        res_unit_valid = 1'b1;
        res_unit       = (|acc_nxt[31:16]) ? UNIT_REPLACE : acc_nxt[UNIT_W-1:0];
        if (cnt_b != '1) begin
          cnt_nxt = cnt_b + COUNT_BITS'(1);
        end
        if (res_unit == '0) begin
          res_cause = CAUSE_NULL;
        end else if (last_in) begin
          res_cause = CAUSE_END;
        end else begin
          res_cause = CAUSE_RUN;
        end
      end

      // Any finishing result halts the string.
      if (res_valid && res_cause != CAUSE_RUN) begin
        halt_nxt = 1'b1;
        pend_nxt = '0;
      end
    end
  end

  // Unit count as shown on the output, saturated to 16 bits.
  generate
    if (COUNT_BITS > UNIT_W) begin : g_cnt_wide
      assign shown_cnt = (|cnt_nxt[COUNT_BITS-1:UNIT_W]) ? '1 : cnt_nxt[UNIT_W-1:0];
    end else if (COUNT_BITS == UNIT_W) begin : g_cnt_same
      assign shown_cnt = cnt_nxt;
    end else begin : g_cnt_narrow
      assign shown_cnt = {{(UNIT_W - COUNT_BITS){1'b0}}, cnt_nxt};
    end
  endgenerate

  always_comb begin
    res_item.code_unit  = res_unit;
    res_item.unit_valid = res_unit_valid;
    res_item.finished   = (res_cause != CAUSE_RUN);
    res_item.end_cause  = res_cause;
    res_item.units_done = shown_cnt;
  end

  // Output register with skid register behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;

    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res_item;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_item;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= '0;
      acc_r        <= '0;
      cnt_r        <= '0;
      halt_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      pend_r       <= pend_nxt;
      acc_r        <= acc_nxt;
      cnt_r        <= cnt_nxt;
      halt_r       <= halt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### sv/u2u_checker.sv
// ----------------------------------------------------------------------------
// u2u_checker
// Port-level checks for the UTF-8 to UCS-2 decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire u2u_pkg::out_item_t out_data
);

  import u2u_pkg::*;

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // The input side stalls only while a result is waiting on the output.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  // The finished mark agrees with the end cause.
  a_finish_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.finished == (out_data.end_cause != CAUSE_RUN)))
    else $error("finished mark disagrees with end cause");

  // A null end always carries a zero unit that was decoded.
  a_null_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_cause == CAUSE_NULL
      |-> out_data.unit_valid && out_data.code_unit == '0)
    else $error("null end without a decoded zero unit");

  // A result without a new unit shows a zero unit.
  a_no_unit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.unit_valid |-> out_data.code_unit == '0 &&
      out_data.finished)
    else $error("result without unit is not a clean finishing result");

endmodule

bind utf8_to_ucs2_decoder_unit u2u_checker u_u2u_checker (.*);

`default_nettype wire

### sim/utf8_to_ucs2_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_unit_test
// Self-checking bench for the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
// A queue of bytes feeds a clocked driver. Each accepted byte is run through
// a local decoder model, and any result it produces is queued as expected.
// A clocked monitor pops the oldest expected result for every result transfer
// and compares it field by field. The stimulus starts with hand-picked
// sequences, then runs random strings under several idle and stall mixes.
// It ends with a long receiver hold-off that backs the block up into its
// input.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import u2u_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Bytes waiting to be offered, and results the model says must come out.
  in_item_t  byte_queue[$];
  out_item_t expected_units[$];

  // Model state of the decoder.
  logic [2:0]  seq_left = '0;
  logic [31:0] seq_acc = '0;
  logic [15:0] str_units = '0;
  logic        str_halted = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_request = 1'b0;
  int hold_left = 0;
  int mismatch_count = 0;

  utf8_to_ucs2_decoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock generation.
  initial begin
    forever #10 clk = ~clk;
  end

  // Run one byte through the decoder model. Returns 1 when a result is due.
  function automatic bit decode_byte(input in_item_t item, output out_item_t res);
    logic [7:0]  b;
    logic [15:0] dec_unit;
    int          ones;
    int          shift;
    bit          emit;
    bit          complete;
    cause_t      cause;
    b = item.byte_value;
    res = '0;
    dec_unit = '0;
    emit = 1'b0;
    complete = 1'b0;
    cause = CAUSE_RUN;
    if (item.first_byte) begin
      seq_left = '0;
      seq_acc = '0;
      str_units = '0;
      str_halted = 1'b0;
    end
    if (str_halted) return 1'b0;
    if (seq_left == 0) begin
      // Lead byte: count the leading ones to get the sequence length.
      ones = 0;
      while (ones < 7 && b[7 - ones]) ones++;
      if (ones == 1 || ones > 6) begin
        emit = item.last_byte;
        cause = CAUSE_END;
      end else if (ones == 0) begin
        seq_acc = {24'd0, b};
        complete = 1'b1;
      end else begin
        seq_acc = (32'(b) & ((32'd1 << (7 - ones)) - 32'd1)) << ((ones - 1) * 6);
        seq_left = 3'(ones - 1);
        emit = item.last_byte;
        cause = CAUSE_BAD;
      end
    end else if (b[7:6] != 2'b10) begin
      emit = 1'b1;
      cause = CAUSE_BAD;
    end else begin
      shift = (int'(seq_left) - 1) * 6;
      seq_acc = seq_acc | (32'(b[5:0]) << shift);
      seq_left = seq_left - 3'd1;
      if (seq_left == 0) begin
        complete = 1'b1;
      end else begin
        emit = item.last_byte;
        cause = CAUSE_BAD;
      end
    end
    // A completed sequence yields one unit; a zero unit ends the string.
    if (complete) begin
      dec_unit = (seq_acc[31:16] != 0) ? UNIT_REPLACE : seq_acc[15:0];
      if (str_units != 16'hFFFF) str_units = str_units + 16'd1;
      emit = 1'b1;
      if (dec_unit == 0) cause = CAUSE_NULL;
      else if (item.last_byte) cause = CAUSE_END;
      else cause = CAUSE_RUN;
    end
    if (!emit) return 1'b0;
    res.code_unit = dec_unit;
    res.unit_valid = complete;
    res.finished = (cause != CAUSE_RUN);
    res.end_cause = cause;
    res.units_done = str_units;
    if (cause != CAUSE_RUN) begin
      str_halted = 1'b1;
      seq_left = '0;
    end
    return 1'b1;
  endfunction

  function automatic in_item_t make_byte(input logic [7:0] b, input bit f, input bit l);
    in_item_t item;
    item.byte_value = b;
    item.first_byte = f;
    item.last_byte = l;
    return item;
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit f, input bit l);
    byte_queue.push_back(make_byte(b, f, l));
  endtask

  // Append a lead byte for a sequence of len bytes and conts continuations.
  task automatic add_seq(ref in_item_t str[$], input int len, input int conts);
    logic [7:0] lead;
    if (len == 1) begin
      lead = 8'($urandom_range(1, 127));
    end else begin
      lead = (8'hFF << (8 - len)) | (8'($urandom) & ((8'd1 << (7 - len)) - 8'd1));
    end
    str.push_back(make_byte(lead, 1'b0, 1'b0));
    for (int i = 0; i < conts; i++) begin
      str.push_back(make_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0, 1'b0));
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 35) return 1;
    if (r < 55) return 2;
    if (r < 75) return 3;
    if (r < 85) return 4;
    if (r < 93) return 5;
    return 6;
  endfunction

  // Build one random string, mostly well formed, and queue it. Bytes after
  // a point where the string is known to halt are not counted.
  task automatic add_string(inout int counted);
    in_item_t str[$];
    int n_chars;
    int kind;
    int len;
    logic [7:0] b;
    bit broke;
    n_chars = $urandom_range(1, 8);
    broke = 1'b0;
    for (int c = 0; c < n_chars && !broke; c++) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        len = pick_len();
        add_seq(str, len, len - 1);
      end else if (kind < 74) begin
        // Null unit ends the string.
        str.push_back(make_byte(8'h00, 1'b0, 1'b0));
        broke = 1'b1;
      end else if (kind < 82) begin
        // Stray continuation or an invalid lead byte; both are skipped.
        if ($urandom_range(1)) b = 8'h80 | 8'($urandom_range(0, 63));
        else b = 8'hFE | 8'($urandom_range(0, 1));
        str.push_back(make_byte(b, 1'b0, 1'b0));
      end else if (kind < 88) begin
        // Sequence cut short by a byte that is not a continuation.
        len = $urandom_range(2, 6);
        add_seq(str, len, $urandom_range(0, len - 2));
        do b = 8'($urandom); while (b[7:6] == 2'b10);
        str.push_back(make_byte(b, 1'b0, 1'b0));
        broke = 1'b1;
      end else if (kind < 94) begin
        str.push_back(make_byte(8'($urandom), 1'b0, 1'b0));
      end else begin
        // Sequence left open at the end of the string.
        len = $urandom_range(2, 6);
        add_seq(str, len, $urandom_range(0, len - 2));
        c = n_chars;
      end
    end
    counted += str.size();
    if (broke) begin
      repeat ($urandom_range(0, 2)) str.push_back(make_byte(8'($urandom), 1'b0, 1'b0));
    end
    str[0].first_byte = ($urandom_range(99) < 95);
    str[str.size() - 1].last_byte = ($urandom_range(99) < 70);
    if (str.size() > 2 && $urandom_range(99) < 8) begin
      str[$urandom_range(str.size() - 2)].last_byte = 1'b1;
    end
    foreach (str[i]) byte_queue.push_back(str[i]);
  endtask

  task automatic add_random_strings(input int target);
    int counted;
    counted = 0;
    while (counted < target) add_string(counted);
  endtask

  task automatic wait_queue_empty();
    while (byte_queue.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%h, got 0x%h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Input driver: predicts each accepted byte, then offers the next one.
  always @(posedge clk) begin : drive_in
    out_item_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (decode_byte(in_data, res)) expected_units.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= byte_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here once requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Output monitor: checks every result transfer against the oldest expectation.
  always @(posedge clk) begin : watch_out
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_units.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got %p", $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_units.pop_front();
          check_field("code_unit", want.code_unit, out_data.code_unit);
          check_field("unit_valid", 16'(want.unit_valid), 16'(out_data.unit_valid));
          check_field("finished", 16'(want.finished), 16'(out_data.finished));
          check_field("end_cause", 16'(want.end_cause), 16'(out_data.end_cause));
          check_field("units_done", want.units_done, out_data.units_done);
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: plain units, sequence lengths one to four and six, skips and string ends.
    push_byte(8'h41, 1, 0);
    push_byte(8'hC3, 0, 0);
    push_byte(8'hA9, 0, 0);
    push_byte(8'hE2, 0, 0);
    push_byte(8'h82, 0, 0);
    push_byte(8'hAC, 0, 0);
    push_byte(8'hF0, 0, 0);
    push_byte(8'h9F, 0, 0);
    push_byte(8'h98, 0, 0);
    push_byte(8'h80, 0, 0);
    push_byte(8'h80, 0, 0);
    push_byte(8'hFF, 0, 0);
    push_byte(8'hFC, 0, 0);
    repeat (4) push_byte(8'h80, 0, 0);
    push_byte(8'h81, 0, 0);
    push_byte(8'h00, 0, 1);
    push_byte(8'h41, 0, 0);
    push_byte(8'hE2, 1, 0);
    push_byte(8'h41, 0, 0);
    push_byte(8'hC3, 1, 1);
    push_byte(8'h80, 1, 1);
    push_byte(8'h7F, 1, 1);
    push_byte(8'hE2, 1, 0);
    push_byte(8'h82, 0, 1);
    wait_queue_empty();

    // Random strings under each idle mix.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      add_random_strings(260);
      wait_queue_empty();
    end

    // Receiver holds off while the sender keeps offering bytes.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_random_strings(200);
    hold_request = 1'b1;
    while (hold_left == 0) @(negedge clk);
    hold_request = 1'b0;
    wait_queue_empty();

    while (in_valid || expected_units.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_units.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, expected_units.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #15_000_000;
    $display("%0t ns: run did not finish in time", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule

### utf8_to_ucs2_decoder_unit.f
sv/u2u_pkg.sv
sv/utf8_to_ucs2_decoder_unit.sv
sv/u2u_checker.sv
sim/utf8_to_ucs2_decoder_unit_test.sv
